FILE: rtl/sast_pkg.sv
// Package for the two-wheel stepper step timer: widths, constants, sequencer
// states and the request and response types of the shared arithmetic unit.
// Has no dependencies; sast_arith and the top level import it.
package sast_pkg;

  localparam int CountWidthDef  = 24;
  localparam int InitStepSecDef = 1000;

  localparam int StepAngleW = 25;
  localparam int AccW       = 33;
  localparam int SpeedW     = 32;
  localparam int TimeW      = 48;
  localparam int OutCountW  = 24;
  localparam int MulW       = 34;
  localparam int NumW       = 64;
  localparam int DenW       = 48;
  localparam int QuoW       = 50;
  localparam int RemW       = 49;
  localparam int IterW      = 6;

  localparam logic [IterW-1:0] SqrtIters     = 6'd32;
  localparam logic [IterW-1:0] TimeDivIters  = 6'd50;
  localparam logic [IterW-1:0] SpeedDivIters = 6'd25;

  localparam logic [StepAngleW-1:0] StepAngleReset = 25'd4216574;
  localparam logic [TimeW-1:0]      TimeMax        = 48'h7FFF_FFFF_FFFF;
  localparam logic signed [SpeedW-1:0] SpeedMax    = 32'sh7FFF_FFFF;
  // One second of Q.16 time is 1e6 microseconds, which is 1e6 / 64 = 15625 after
  // dividing both sides of the deadline compare by 64.
  localparam logic signed [MulW-1:0] UsScale       = 34'sd15625;
  localparam logic signed [TimeW:0]  CmpLimit      = 49'sd536870912;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } arith_op_e;

  typedef struct packed {
    logic             start;
    arith_op_e        op;
    logic [IterW-1:0] iters;
  } arith_req_t;

  typedef struct packed {
    logic            busy;
    logic [QuoW-1:0] quo;
  } arith_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_AS,
    ST_RAD,
    ST_FLIP,
    ST_SQRT,
    ST_SQRT_W,
    ST_TDIV,
    ST_TDIV_W,
    ST_TSET,
    ST_ELAP,
    ST_CMP,
    ST_WDIV,
    ST_WDIV_W,
    ST_WSET,
    ST_NEXT
  } st_e;

endpackage

FILE: rtl/sast_in_if.sv
// Input channel of the stepper step timer: valid, ready and one tick's
// acceleration commands. No dependencies.
interface sast_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] balance_accel;
  logic signed [31:0] turn_accel;
  logic               restart;

  modport source (output valid, balance_accel, turn_accel, restart, input ready);
  modport sink   (input valid, balance_accel, turn_accel, restart, output ready);
endinterface

FILE: rtl/sast_out_if.sv
// Output channel of the stepper step timer: valid, ready and the pin levels,
// counts and speeds after one tick. No dependencies.
interface sast_out_if;
  logic               valid;
  logic               ready;
  logic               left_step_level;
  logic               right_step_level;
  logic               left_dir_level;
  logic               right_dir_level;
  logic signed [23:0] left_count;
  logic signed [23:0] right_count;
  logic signed [31:0] left_speed;
  logic signed [31:0] right_speed;

  modport source (output valid, left_step_level, right_step_level, left_dir_level,
                  right_dir_level, left_count, right_count, left_speed, right_speed,
                  input ready);
  modport sink   (input valid, left_step_level, right_step_level, left_dir_level,
                  right_dir_level, left_count, right_count, left_speed, right_speed,
                  output ready);
endinterface

FILE: rtl/sast_arith.sv
// Shared shift-subtract unit: unsigned restoring division one quotient bit a
// cycle, or integer square root one root bit a cycle. Depends on sast_pkg.
module sast_arith import sast_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  arith_req_t      req_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output arith_rsp_t      rsp_o
);

  logic             busy_q;
  arith_op_e        op_q;
  logic [IterW-1:0] cnt_q;
  logic [NumW-1:0]  num_q;
  logic [DenW-1:0]  den_q;
  logic [RemW-1:0]  rem_q;
  logic [QuoW-1:0]  quo_q;

  logic [RemW-1:0]  opa, opb;
  logic [RemW:0]    diff;
  logic             ge;

  always_comb begin
    unique case (op_q)
      OP_SQRT: begin
        opa = {rem_q[RemW-3:0], num_q[NumW-1 -: 2]};
        opb = {quo_q[RemW-3:0], 2'b01};
      end
      default: begin
        opa = {rem_q[RemW-2:0], num_q[NumW-1]};
        opb = {1'b0, den_q};
      end
    endcase
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = ~diff[RemW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_DIV;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.iters;
      op_q   <= req_i.op;
    end else if (busy_q) begin
      cnt_q <= cnt_q - IterW'(1);
      if (cnt_q == IterW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[RemW-1:0] : opa;
      quo_q <= {quo_q[QuoW-2:0], ge};
      num_q <= (op_q == OP_SQRT) ? {num_q[NumW-3:0], 2'b00} : {num_q[NumW-2:0], 1'b0};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = quo_q;

endmodule

FILE: rtl/stepper_accel_step_timer_top.sv
// Top level of the two-wheel stepper step timer: sequencer, per-wheel state,
// one shared multiplier and the shared divide/root unit. Depends on sast_pkg,
// sast_in_if, sast_out_if and sast_arith.
//
// Usage: one input transaction per microsecond tick on in_i carries the
// balance and turn accelerations and a restart flag. Each accepted tick gives
// exactly one output transaction on out_o with both wheels' step and
// direction pin levels, wrapping step counts and signed speeds after the tick.
// The step angle register is written through cfg_we_i / cfg_data_i; it takes
// effect at once. The user must write it only while the block is idle; the
// block itself does not enforce this. The two wheels are worked one after the
// other through the same hardware. Per wheel: the radicand, the 32-step square
// root, the 50-step step-time division and its write when the acceleration is
// non-zero, the deadline compare, the 25-step speed division and its write
// when the wheel steps with a non-zero step time, and a closing state. in_i is
// not ready again until the sequencer is back in idle.
// The result sits in an output register, so the next tick is accepted while
// it waits; a stalled receiver only holds up the end of the following tick.
// Reset sets both steps positive, all pins high, speeds and counts to zero
// and step times to INITIAL_STEP_SECONDS.
module stepper_accel_step_timer_top import sast_pkg::*; #(
  parameter int COUNT_WIDTH          = CountWidthDef,
  parameter int INITIAL_STEP_SECONDS = InitStepSecDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [StepAngleW-1:0] cfg_data_i,
  sast_in_if.sink               in_i,
  sast_out_if.source            out_o
);

  localparam int CntExtW = (COUNT_WIDTH > OutCountW) ? COUNT_WIDTH : OutCountW;
  localparam logic signed [TimeW-1:0] InitTime =
      $signed(TimeW'(INITIAL_STEP_SECONDS) << 16);

  st_e state_q, state_d;

  logic                        wheel_q;
  logic [StepAngleW-1:0]       step_angle_q;
  logic signed [31:0]          bal_q, turn_q;
  logic                        restart_q;
  logic [3:0]                  pins_q;
  logic signed [SpeedW-1:0]    w0_q [2];
  logic signed [TimeW-1:0]     tstep_q [2];
  logic [31:0]                 elap_q [2];
  logic [COUNT_WIDTH-1:0]      cnt_q [2];
  logic signed [SpeedW-1:0]    spd_q [2];
  logic signed [63:0]          sq_q, rad_q;
  logic signed [2*MulW-1:0]    prod_q;
  logic [31:0]                 w_q;

  logic                        out_valid_q;
  logic [3:0]                  out_pins_q;
  logic [OutCountW-1:0]        out_lcnt_q, out_rcnt_q;
  logic signed [SpeedW-1:0]    out_lspd_q, out_rspd_q;

  // Shared unit and multiplier control
  arith_req_t                  areq;
  arith_rsp_t                  arsp;
  logic [NumW-1:0]             anum;
  logic [DenW-1:0]             aden;
  logic                        mul_en;
  logic signed [MulW-1:0]      mul_a, mul_b;
  logic signed [2*MulW-1:0]    mul_p;
  logic                        in_ready;

  // Per-wheel derived values
  logic signed [AccW-1:0]      acc;
  logic [AccW-1:0]             amag;
  logic                        pos;
  logic signed [StepAngleW:0]  s_val;
  logic signed [SpeedW-1:0]    w0;
  logic signed [TimeW-1:0]     tcur;
  logic [31:0]                 ecur, einc;
  logic signed [63:0]          rad1, rad2;
  logic signed [33:0]          wdiff;
  logic [32:0]                 wmag;
  logic [TimeW-1:0]            tsat, tden;
  logic signed [TimeW-1:0]     tnew;
  logic signed [TimeW:0]       ts;
  logic                        fire;
  logic                        negate;
  logic signed [SpeedW-1:0]    nw_zero, nw_div;
  logic                        out_free;

  logic [3:0]                  pins_fin;
  logic signed [CntExtW-1:0]   lext, rext;

  always_comb begin
    acc    = wheel_q ? (AccW'(turn_q) + AccW'(bal_q)) : (AccW'(turn_q) - AccW'(bal_q));
    amag   = acc[AccW-1] ? AccW'(-acc) : acc;
    pos    = pins_q[{1'b1, wheel_q}];
    s_val  = pos ? $signed({1'b0, step_angle_q}) : -$signed({1'b0, step_angle_q});
    w0     = w0_q[wheel_q];
    tcur   = tstep_q[wheel_q];
    ecur   = elap_q[wheel_q];
    einc   = (ecur == '1) ? ecur : ecur + 32'd1;
    // The floored 2*a*s/2^16 is the product a*s shifted right by 15.
    rad1   = sq_q + 64'(prod_q >>> 15);
    rad2   = sq_q + 64'((-prod_q) >>> 15);
    wdiff  = $signed({2'b00, w_q}) - 34'(w0);
    wmag   = wdiff[33] ? 33'(-wdiff) : wdiff[32:0];
    tsat   = (arsp.quo > QuoW'(TimeMax)) ? TimeMax : arsp.quo[TimeW-1:0];
    tnew   = (wdiff[33] ^ acc[AccW-1]) ? -$signed(tsat) : $signed(tsat);
    tden   = tcur[TimeW-1] ? TimeW'(-tcur) : tcur;
    ts     = pos ? (TimeW+1)'(tcur) : -((TimeW+1)'(tcur));
    fire   = ts[TimeW] || (ts == '0) ||
             ((ts < CmpLimit) && ({6'b0, ecur, 10'b0} >= prod_q[47:0]));
    negate = (pos != wheel_q);
    if (step_angle_q == '0) begin
      nw_zero = '0;
    end else begin
      nw_zero = pos ? SpeedMax : -SpeedMax;
    end
    nw_div = ((!pos) ^ tcur[TimeW-1]) ? -$signed(SpeedW'(arsp.quo[StepAngleW:0]))
                                      : $signed(SpeedW'(arsp.quo[StepAngleW:0]));
    out_free = !out_valid_q || out_o.ready;
  end

  assign mul_p = mul_a * mul_b;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_i.valid) state_d = ST_SQ;
      ST_SQ:     state_d = ST_AS;
      ST_AS:     state_d = ST_RAD;
      ST_RAD:    state_d = ST_FLIP;
      ST_FLIP:   state_d = ST_SQRT;
      ST_SQRT:   state_d = ST_SQRT_W;
      ST_SQRT_W: if (!arsp.busy) state_d = (acc != '0) ? ST_TDIV : ST_ELAP;
      ST_TDIV:   state_d = ST_TDIV_W;
      ST_TDIV_W: if (!arsp.busy) state_d = ST_TSET;
      ST_TSET:   state_d = ST_ELAP;
      ST_ELAP:   state_d = ST_CMP;
      ST_CMP:    state_d = (fire && (tcur != '0)) ? ST_WDIV : ST_NEXT;
      ST_WDIV:   state_d = ST_WDIV_W;
      ST_WDIV_W: if (!arsp.busy) state_d = ST_WSET;
      ST_WSET:   state_d = ST_NEXT;
      ST_NEXT: begin
        if (!wheel_q) begin
          state_d = ST_SQ;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    areq.start = 1'b0;
    areq.op    = OP_DIV;
    areq.iters = TimeDivIters;
    anum       = {1'b0, wmag, 16'b0, 14'b0};
    aden       = DenW'(amag);
    mul_en     = 1'b0;
    mul_a      = MulW'(w0);
    mul_b      = MulW'(w0);
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_SQ:   mul_en = 1'b1;
      ST_AS: begin
        mul_en = 1'b1;
        mul_a  = MulW'(acc);
        mul_b  = MulW'(s_val);
      end
      ST_SQRT: begin
        areq.start = 1'b1;
        areq.op    = OP_SQRT;
        areq.iters = SqrtIters;
        anum       = rad_q;
      end
      ST_TDIV: areq.start = 1'b1;
      ST_ELAP: begin
        mul_en = 1'b1;
        mul_a  = ts[MulW-1:0];
        mul_b  = UsScale;
      end
      ST_WDIV: begin
        areq.start = 1'b1;
        areq.iters = SpeedDivIters;
        anum       = {step_angle_q, (NumW - StepAngleW)'(0)};
        aden       = tden;
      end
      default: ;
    endcase
  end

  sast_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (areq),
    .num_i  (anum),
    .den_i  (aden),
    .rsp_o  (arsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    pins_fin = restart_q ? (pins_q | 4'b1100) : pins_q;
    lext     = CntExtW'($signed(cnt_q[0]));
    rext     = CntExtW'($signed(cnt_q[1]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q      <= 1'b0;
      step_angle_q <= StepAngleReset;
      pins_q       <= 4'b1111;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        w0_q[i]    <= '0;
        tstep_q[i] <= InitTime;
        elap_q[i]  <= '0;
        cnt_q[i]   <= '0;
        spd_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        step_angle_q <= cfg_data_i;
      end
      if (out_valid_q && out_o.ready && !(state_q == ST_NEXT && wheel_q && out_free)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_FLIP: begin
          if (rad_q[63]) begin
            pins_q[{1'b1, wheel_q}] <= ~pos;
          end
        end
        ST_TSET: tstep_q[wheel_q] <= tnew;
        ST_ELAP: elap_q[wheel_q] <= einc;
        ST_CMP: begin
          if (fire) begin
            pins_q[{1'b0, wheel_q}] <= ~pins_q[{1'b0, wheel_q}];
            cnt_q[wheel_q] <= negate ? cnt_q[wheel_q] - COUNT_WIDTH'(1)
                                     : cnt_q[wheel_q] + COUNT_WIDTH'(1);
            elap_q[wheel_q] <= '0;
            if (tcur == '0) begin
              w0_q[wheel_q]  <= nw_zero;
              spd_q[wheel_q] <= negate ? -nw_zero : nw_zero;
            end
          end
        end
        ST_WSET: begin
          w0_q[wheel_q]  <= nw_div;
          spd_q[wheel_q] <= negate ? -nw_div : nw_div;
        end
        ST_NEXT: begin
          if (!wheel_q) begin
            wheel_q <= 1'b1;
          end else if (out_free) begin
            wheel_q     <= 1'b0;
            out_valid_q <= 1'b1;
            pins_q      <= pins_fin;
            if (restart_q) begin
              for (int i = 0; i < 2; i++) begin
                w0_q[i]    <= '0;
                tstep_q[i] <= InitTime;
                elap_q[i]  <= '0;
                cnt_q[i]   <= '0;
                spd_q[i]   <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and scratch registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      bal_q     <= in_i.balance_accel;
      turn_q    <= in_i.turn_accel;
      restart_q <= in_i.restart;
    end
    if (mul_en) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_AS) begin
      sq_q <= prod_q[63:0];
    end
    if (state_q == ST_RAD) begin
      rad_q <= rad1;
    end
    // A negative radicand flips the step; the recomputed one is clamped at 0.
    if (state_q == ST_FLIP && rad_q[63]) begin
      rad_q <= rad2[63] ? '0 : rad2;
    end
    if (state_q == ST_SQRT_W && !arsp.busy) begin
      w_q <= arsp.quo[31:0];
    end
    if (state_q == ST_NEXT && wheel_q && out_free) begin
      out_pins_q <= pins_fin;
      out_lcnt_q <= restart_q ? '0 : lext[OutCountW-1:0];
      out_rcnt_q <= restart_q ? '0 : rext[OutCountW-1:0];
      out_lspd_q <= restart_q ? '0 : spd_q[0];
      out_rspd_q <= restart_q ? '0 : spd_q[1];
    end
  end

  assign in_i.ready             = in_ready;
  assign out_o.valid            = out_valid_q;
  assign out_o.left_step_level  = out_pins_q[0];
  assign out_o.right_step_level = out_pins_q[1];
  assign out_o.left_dir_level   = out_pins_q[2];
  assign out_o.right_dir_level  = out_pins_q[3];
  assign out_o.left_count       = $signed(out_lcnt_q);
  assign out_o.right_count      = $signed(out_rcnt_q);
  assign out_o.left_speed       = out_lspd_q;
  assign out_o.right_speed      = out_rspd_q;

endmodule

FILE: rtl/sast_chk.sv
// Port-level checker for the stepper step timer and the bind that attaches
// it to stepper_accel_step_timer_top. Depends on the top level's ports.
module sast_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [23:0] out_left_count_i,
  input logic signed [23:0] out_right_count_i
);

  // A tick keeps the sequencer busy, so no transaction follows at once.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again directly after a transaction");

  // A fresh result is only posted as the sequencer returns to idle.
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result posted while a tick is still being worked");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_left_count_i) && $stable(out_right_count_i))
    else $error("output counts changed while stalled");

endmodule

bind stepper_accel_step_timer_top sast_chk u_sast_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_left_count_i  (out_o.left_count),
  .out_right_count_i (out_o.right_count)
);
